// ----- rtl/core/rtp_reorder_queue_defines.svh -----
// assertion macros for the reorder queue checker
`ifndef RTP_REORDER_QUEUE_DEFINES_SVH
`define RTP_REORDER_QUEUE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define RTQ_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rtq assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define RTQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rtq assertion failed");

`endif

// ----- rtl/core/rtq_pkg.sv -----
// types, codes and helpers shared by the reorder queue modules
package rtq_pkg;

   localparam int SEQ_W       = 16;
   localparam int HANDLE_W    = 16;
   localparam int LEN_W       = 11;
   localparam int STATUS_W    = 3;
   localparam int QCOUNT_W    = 7;
   localparam int MAXE_W      = 7;
   localparam int DEPTH_W     = 6;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 7;
   localparam int REQ_TDATA_W = 48;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 72;
   localparam int RSP_TUSER_W = 3;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_LATE     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_POPPED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NONE     = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ENTRIES   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_DEPTH = 1'd1;

   localparam logic [MAXE_W-1:0]  MAXE_RESET  = 7'd64;
   localparam logic [DEPTH_W-1:0] DEPTH_RESET = 6'd8;

   typedef struct packed {
      logic [SEQ_W-1:0]    seq;
      logic [HANDLE_W-1:0] handle;
      logic [LEN_W-1:0]    len;
   } rtq_entry_type;

   typedef struct packed {
      logic capture;     // latch compare results in every cell
      logic insert;      // open a gap at the insert point and drop the key in
      logic shift_down;  // every cell takes its upper neighbor
   } rtq_cell_ctl_type;

   // wrap-aware order: a before b when b - a is 1 .. 0x7fff
   function automatic logic seq_before(input logic [SEQ_W-1:0] a,
                                       input logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] d;
      d = b - a;
      return (d != '0) && !d[SEQ_W-1];
   endfunction

endpackage

// ----- rtl/core/rtq_cell.sv -----
// one slot of the sorted queue: holds an entry and compares it to the key
module rtq_cell (
   input  logic                     clock,
   input  rtq_pkg::rtq_cell_ctl_type ctl,
   input  rtq_pkg::rtq_entry_type    key,
   input  rtq_pkg::rtq_entry_type    below,
   input  rtq_pkg::rtq_entry_type    above,
   input  logic                     valid,
   input  logic                     ge_self,
   input  logic                     hit_below,
   output rtq_pkg::rtq_entry_type    entry,
   output logic                     hit,
   output logic                     eq
);

   rtq_pkg::rtq_entry_type entry_ff, entry_in;
   logic hit_ff, hit_in;
   logic eq_ff, eq_in;

   always_comb begin
      eq_in  = valid && (entry_ff.seq == key.seq);
      hit_in = eq_in || (valid && rtq_pkg::seq_before(entry_ff.seq, key.seq));
   end

   // a hit at or above this slot keeps it; the slot just above the top hit gets the key
   always_comb begin
      priority if (ctl.shift_down) begin
         entry_in = above;
      end else if (ctl.insert && !ge_self && hit_below) begin
         entry_in = key;
      end else if (ctl.insert && !ge_self) begin
         entry_in = below;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (ctl.capture) begin
         hit_ff <= hit_in;
         eq_ff  <= eq_in;
      end
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;
   assign eq    = eq_ff;

endmodule

// ----- rtl/core/rtq_chain.sv -----
// row of queue cells, oldest entry in cell 0, with the insert-point search
module rtq_chain #(
   parameter int unsigned CELLS = 65,
   parameter int unsigned CNT_W = 7
) (
   input  logic                     clock,
   input  rtq_pkg::rtq_cell_ctl_type ctl,
   input  rtq_pkg::rtq_entry_type    key,
   input  logic [CNT_W-1:0]         count,
   output rtq_pkg::rtq_entry_type    head,
   output logic                     dup
);

   rtq_pkg::rtq_entry_type ent [CELLS];
   logic [CELLS-1:0] hit_vec;
   logic [CELLS-1:0] eq_vec;
   logic [CELLS-1:0] ge_vec;
   logic [CELLS-1:0] top_vec;

   for (genvar j = 0; j < CELLS; j++) begin : g_cell
      rtq_pkg::rtq_entry_type below_j, above_j;
      logic valid_j, hit_below_j;

      // any hit at this slot or higher
      assign ge_vec[j] = (hit_vec >> j) != '0;
      assign valid_j   = count > CNT_W'(j);

      if (j == 0) begin : g_bottom
         assign below_j     = key;
         assign hit_below_j = 1'b1;
      end else begin : g_mid_lo
         assign below_j     = ent[j-1];
         assign hit_below_j = hit_vec[j-1];
      end

      if (j == CELLS - 1) begin : g_top
         assign above_j    = ent[j];
         assign top_vec[j] = hit_vec[j];
      end else begin : g_mid_hi
         assign above_j    = ent[j+1];
         assign top_vec[j] = hit_vec[j] && !ge_vec[j+1];
      end

      rtq_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .key       (key),
         .below     (below_j),
         .above     (above_j),
         .valid     (valid_j),
         .ge_self   (ge_vec[j]),
         .hit_below (hit_below_j),
         .entry     (ent[j]),
         .hit       (hit_vec[j]),
         .eq        (eq_vec[j])
      );
   end

   // the scan stops at the highest hit; it is a duplicate if that slot matched exactly
   assign dup  = (top_vec & eq_vec) != '0;
   assign head = ent[0];

endmodule

// ----- rtl/core/rtp_reorder_queue.sv -----
// reorder queue for packet descriptors, sorted by wrap-aware sequence number
//
//   channel | direction | tdata / data                         | tuser / index
//   req_    | in        | seq_num, packet_handle, packet_length | req_type, depth_bypass
//   rsp_    | out       | out_seq .. data_ready                 | status
//   csr_    | in        | register value                       | register index
//
// an item passes through the capture of the compares in every cell, the insert
// or pop shift along the cell row, and the load of the output register, in that
// order; each entry evicted on a push adds a shift of the row down by one.
// a result waiting in the output register does not stop the next item; the row
// waits only when a second result is ready before the first is taken.
// reset is synchronous and empties the queue and restores the register defaults.
module rtp_reorder_queue #(
   parameter int unsigned CAPACITY       = 64,
   parameter int unsigned FALLBACK_MAX   = 64,
   parameter int unsigned FALLBACK_DEPTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // seq_num [15:0], packet_handle [31:16], packet_length [42:32], zero [47:43]
   input  logic [rtq_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // req_type [0], depth_bypass [1]
   input  logic [rtq_pkg::REQ_TUSER_W-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_seq [15:0], out_handle [31:16], out_length [42:32], evicted [43],
   // evicted_handle [59:44], queue_count [66:60], data_ready [67], zero [71:68]
   output logic [rtq_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // status [2:0]
   output logic [rtq_pkg::RSP_TUSER_W-1:0]     rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rtq_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rtq_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int unsigned CELLS = CAPACITY + 1;
   localparam int unsigned CNT_W = $clog2(CAPACITY + 2);
   localparam int unsigned LIM_A = (CELLS > FALLBACK_MAX) ? CELLS : FALLBACK_MAX;
   localparam int unsigned LIM_B = (LIM_A > FALLBACK_DEPTH) ? LIM_A : FALLBACK_DEPTH;
   localparam int unsigned LIM   = (LIM_B > 127) ? LIM_B : 127;
   localparam int unsigned LW    = $clog2(LIM + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EVAL   = 3'd1;
   localparam logic [2:0] S_ACT    = 3'd2;
   localparam logic [2:0] S_EVICT  = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [rtq_pkg::SEQ_W-1:0] last_rel_ff, last_rel_in;
   logic rel_any_ff, rel_any_in;
   logic [rtq_pkg::MAXE_W-1:0] maxe_ff, maxe_in;
   logic [rtq_pkg::DEPTH_W-1:0] depth_ff, depth_in;
   logic rsp_tvalid_ff, rsp_tvalid_in;

   rtq_pkg::rtq_entry_type key_ff, key_in;
   logic push_ff, push_in;
   logic ign_ff, ign_in;
   logic [rtq_pkg::STATUS_W-1:0] status_ff, status_in;
   rtq_pkg::rtq_entry_type pop_ff, pop_in;
   logic ev_ff, ev_in;
   logic [rtq_pkg::HANDLE_W-1:0] evh_ff, evh_in;
   logic [rtq_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [rtq_pkg::RSP_TUSER_W-1:0] rsp_tuser_ff, rsp_tuser_in;

   rtq_pkg::rtq_cell_ctl_type ctl;
   rtq_pkg::rtq_entry_type head;
   logic dup;

   logic [LW-1:0] me, de, mx, dp, count_l;
   logic [rtq_pkg::SEQ_W-1:0] lag;
   logic late, can_pop, over, more, out_free, accept, data_ready;
   logic [CNT_W-1:0] count_act, count_ev;

   // effective limits: fall back when the depth is not below the maximum, then clamp the maximum to the capacity
   always_comb begin
      me = LW'(maxe_ff);
      de = LW'(depth_ff);
      if (de >= me) begin
         mx = LW'(FALLBACK_MAX);
         dp = LW'(FALLBACK_DEPTH);
      end else begin
         mx = me;
         dp = de;
      end
      if (mx > LW'(CAPACITY)) begin
         mx = LW'(CAPACITY);
      end
   end

   assign count_l    = LW'(count_ff);
   assign lag        = last_rel_ff - key_ff.seq;
   // at or before the last released number
   assign late       = rel_any_ff && !lag[rtq_pkg::SEQ_W-1];
   assign can_pop    = (count_ff != '0) && (ign_ff || count_l >= dp);
   assign data_ready = count_l >= dp;
   assign count_ev   = count_ff - CNT_W'(1);
   assign more       = LW'(count_ev) > mx;

   always_comb begin
      if (push_ff == rtq_pkg::REQ_PUSH) begin
         count_act = (late || dup) ? count_ff : count_ff + CNT_W'(1);
      end else begin
         count_act = can_pop ? count_ev : count_ff;
      end
   end

   assign over = (push_ff == rtq_pkg::REQ_PUSH) && !late && (LW'(count_act) > mx);

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) || ((state_ff == S_FINISH) && out_free);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      ctl.capture    = state_ff == S_EVAL;
      ctl.insert     = (state_ff == S_ACT) && (push_ff == rtq_pkg::REQ_PUSH) && !late && !dup;
      ctl.shift_down = ((state_ff == S_ACT) && (push_ff == rtq_pkg::REQ_POP) && can_pop) ||
                       (state_ff == S_EVICT);
   end

   rtq_chain #(
      .CELLS (CELLS),
      .CNT_W (CNT_W)
   ) u_chain (
      .clock (clock),
      .ctl   (ctl),
      .key   (key_ff),
      .count (count_ff),
      .head  (head),
      .dup   (dup)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      last_rel_in   = last_rel_ff;
      rel_any_in    = rel_any_ff;
      maxe_in       = maxe_ff;
      depth_in      = depth_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      key_in        = key_ff;
      push_in       = push_ff;
      ign_in        = ign_ff;
      status_in     = status_ff;
      pop_in        = pop_ff;
      ev_in         = ev_ff;
      evh_in        = evh_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;

      if (csr_valid) begin
         unique case (csr_index)
            rtq_pkg::CSR_MAX_ENTRIES:   maxe_in  = csr_data;
            rtq_pkg::CSR_RELEASE_DEPTH: depth_in = csr_data[rtq_pkg::DEPTH_W-1:0];
            default: ;
         endcase
      end

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      if (accept) begin
         key_in.seq    = req_tdata[15:0];
         key_in.handle = req_tdata[31:16];
         key_in.len    = req_tdata[42:32];
         push_in       = req_tuser[0];
         ign_in        = req_tuser[1];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EVAL;
         end
         S_EVAL: begin
            state_in = S_ACT;
         end
         S_ACT: begin
            count_in = count_act;
            pop_in   = '0;
            ev_in    = 1'b0;
            evh_in   = '0;
            if (push_ff == rtq_pkg::REQ_PUSH) begin
               priority if (late) status_in = rtq_pkg::ST_LATE;
               else if (dup)     status_in = rtq_pkg::ST_DUP;
               else              status_in = rtq_pkg::ST_INSERTED;
            end else if (can_pop) begin
               status_in   = rtq_pkg::ST_POPPED;
               pop_in      = head;
               last_rel_in = head.seq;
               rel_any_in  = 1'b1;
            end else begin
               status_in = rtq_pkg::ST_NONE;
            end
            state_in = over ? S_EVICT : S_FINISH;
         end
         S_EVICT: begin
            count_in = count_ev;
            ev_in    = 1'b1;
            evh_in   = head.handle;
            if (!more) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = status_ff;
               rsp_tdata_in  = {4'd0, data_ready, rtq_pkg::QCOUNT_W'(count_ff), evh_ff,
                                ev_ff, pop_ff.len, pop_ff.handle, pop_ff.seq};
               state_in      = accept ? S_EVAL : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         last_rel_ff   <= '0;
         rel_any_ff    <= 1'b0;
         maxe_ff       <= rtq_pkg::MAXE_RESET;
         depth_ff      <= rtq_pkg::DEPTH_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         last_rel_ff   <= last_rel_in;
         rel_any_ff    <= rel_any_in;
         maxe_ff       <= maxe_in;
         depth_ff      <= depth_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      push_ff      <= push_in;
      ign_ff       <= ign_in;
      status_ff    <= status_in;
      pop_ff       <= pop_in;
      ev_ff        <= ev_in;
      evh_ff       <= evh_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// ----- rtl/core/rtq_checker.sv -----
// port-level checks on the reorder queue, bound to the top level
`include "rtp_reorder_queue_defines.svh"

module rtq_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [rtq_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input logic [rtq_pkg::RSP_TUSER_W-1:0]    rsp_tuser
);

   logic rsp_not_pop;
   logic rsp_late;

   assign rsp_not_pop = rsp_tvalid && (rsp_tuser != rtq_pkg::ST_POPPED);
   assign rsp_late    = rsp_tvalid && (rsp_tuser == rtq_pkg::ST_LATE);

   // nothing is offered right after reset
   `RTQ_ASSERT_IMP(a_quiet_after_reset, $past(reset), !rsp_tvalid)

   // only a pop carries packet fields
   `RTQ_ASSERT_IMP(a_fields_only_on_pop, rsp_not_pop, rsp_tdata[42:0] == 43'd0)

   // a late drop never evicts
   `RTQ_ASSERT_IMP(a_late_no_evict, rsp_late, !rsp_tdata[43] && (rsp_tdata[59:44] == 16'd0))

   // a stalled item holds
   `RTQ_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind rtp_reorder_queue rtq_checker u_rtq_checker (.*);

// ----- sim/tb_rtp_reorder_queue.sv -----
// self-checking testbench for the rtp_reorder_queue packet reorder buffer
module tb_rtp_reorder_queue;

   localparam int unsigned QCAP     = 64;
   localparam int unsigned FB_MAX   = 64;
   localparam int unsigned FB_DEPTH = 8;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 250;

   typedef struct packed {
      logic                         kind;
      logic                         ign;
      logic [rtq_pkg::SEQ_W-1:0]    seq;
      logic [rtq_pkg::HANDLE_W-1:0] handle;
      logic [rtq_pkg::LEN_W-1:0]    len;
   } pkt_cmd_type;

   typedef struct packed {
      logic [rtq_pkg::STATUS_W-1:0] status;
      logic [rtq_pkg::SEQ_W-1:0]    out_seq;
      logic [rtq_pkg::HANDLE_W-1:0] out_handle;
      logic [rtq_pkg::LEN_W-1:0]    out_length;
      logic                         evicted;
      logic [rtq_pkg::HANDLE_W-1:0] evicted_handle;
      logic [rtq_pkg::QCOUNT_W-1:0] queue_count;
      logic                         data_ready;
   } pkt_result_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [rtq_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic [rtq_pkg::REQ_TUSER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [rtq_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [rtq_pkg::RSP_TUSER_W-1:0] rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [rtq_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [rtq_pkg::CSR_DATA_W-1:0] csr_data = '0;

   rtp_reorder_queue #(
      .CAPACITY(QCAP),
      .FALLBACK_MAX(FB_MAX),
      .FALLBACK_DEPTH(FB_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   pkt_cmd_type    pkt_backlog[$];
   pkt_result_type owed_results[$];
   pkt_cmd_type    req_item;
   logic        req_taken = 1'b0;
   int          idle_pct = 14;
   int          stall_asks = 0;
   int          stall_seen = 0;
   int          hold_left = 0;
   int          mismatches = 0;
   int          stale_cycles = 0;

   // shadow of the queue contents and registers
   rtq_pkg::rtq_entry_type    slot [0:QCAP];
   int unsigned               held = 0;
   logic [rtq_pkg::SEQ_W-1:0] last_out = '0;
   bit                        have_released = 1'b0;
   logic [rtq_pkg::MAXE_W-1:0]  max_reg = rtq_pkg::MAXE_RESET;
   logic [rtq_pkg::DEPTH_W-1:0] depth_reg = rtq_pkg::DEPTH_RESET;

   function automatic bit seq_ahead_of(input logic [rtq_pkg::SEQ_W-1:0] a,
                                       input logic [rtq_pkg::SEQ_W-1:0] b);
      logic [rtq_pkg::SEQ_W-1:0] gap;
      gap = b - a;
      return (gap != 0) && (gap < 16'h8000);
   endfunction

   function automatic void drop_head();
      int unsigned i;
      for (i = 0; i + 1 < held; i++) slot[i] = slot[i+1];
      held--;
   endfunction

   function automatic pkt_result_type reorder_step(input pkt_cmd_type c);
      pkt_result_type r;
      int unsigned lim, thr, pos, k;
      bit dup, found;
      r = '0;
      lim = max_reg;
      thr = depth_reg;
      if (thr >= lim) begin
         lim = FB_MAX;
         thr = FB_DEPTH;
      end
      if (lim > QCAP) lim = QCAP;
      if (c.kind == rtq_pkg::REQ_PUSH) begin
         if (have_released && (seq_ahead_of(c.seq, last_out) || c.seq == last_out)) begin
            r.status = rtq_pkg::ST_LATE;
         end else begin
            dup = 1'b0;
            found = 1'b0;
            pos = 0;
            k = held;
            // walk down from the newest entry to find the insert point
            while (k > 0 && !found) begin
               if (slot[k-1].seq == c.seq) begin
                  dup = 1'b1;
                  found = 1'b1;
               end else if (seq_ahead_of(slot[k-1].seq, c.seq)) begin
                  pos = k;
                  found = 1'b1;
               end else begin
                  k--;
               end
            end
            if (dup) begin
               r.status = rtq_pkg::ST_DUP;
            end else begin
               r.status = rtq_pkg::ST_INSERTED;
               for (k = held; k > pos; k--) slot[k] = slot[k-1];
               slot[pos].seq = c.seq;
               slot[pos].handle = c.handle;
               slot[pos].len = c.len;
               held++;
            end
            // a lowered maximum can take several entries out at once
            while (held > lim) begin
               r.evicted = 1'b1;
               r.evicted_handle = slot[0].handle;
               drop_head();
            end
         end
      end else if (held > 0 && (c.ign || held >= thr)) begin
         r.status = rtq_pkg::ST_POPPED;
         r.out_seq = slot[0].seq;
         r.out_handle = slot[0].handle;
         r.out_length = slot[0].len;
         last_out = slot[0].seq;
         have_released = 1'b1;
         drop_head();
      end else begin
         r.status = rtq_pkg::ST_NONE;
      end
      r.queue_count = held[rtq_pkg::QCOUNT_W-1:0];
      r.data_ready = (held >= thr);
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s expected %0h actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // item still on offer
      end else if (pkt_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
         req_item <= pkt_backlog[0];
         req_tdata <= {pkt_backlog[0].len, pkt_backlog[0].handle, pkt_backlog[0].seq};
         req_tuser <= {pkt_backlog[0].ign, pkt_backlog[0].kind};
         req_tvalid <= 1'b1;
         void'(pkt_backlog.pop_front());
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // response ready, with a long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (stall_asks != stall_seen) begin
         stall_seen <= stall_asks;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      pkt_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready)
            owed_results.insert(owed_results.size(), reorder_step(req_item));
         if (rsp_tvalid && rsp_tready) begin
            if (owed_results.size() == 0) begin
               $error("result item arrived with none outstanding");
               mismatches++;
            end else begin
               want = owed_results.pop_front();
               check_field("status", want.status, rsp_tuser[2:0]);
               check_field("out_seq", want.out_seq, rsp_tdata[15:0]);
               check_field("out_handle", want.out_handle, rsp_tdata[31:16]);
               check_field("out_length", want.out_length, rsp_tdata[42:32]);
               check_field("evicted", want.evicted, rsp_tdata[43]);
               check_field("evicted_handle", want.evicted_handle, rsp_tdata[59:44]);
               check_field("queue_count", want.queue_count, rsp_tdata[66:60]);
               check_field("data_ready", want.data_ready, rsp_tdata[67]);
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stale_cycles <= 0;
      end else begin
         stale_cycles <= stale_cycles + 1;
         if (stale_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [rtq_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rtq_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      if (idx == rtq_pkg::CSR_MAX_ENTRIES) max_reg = val;
      else depth_reg = val[rtq_pkg::DEPTH_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input int unsigned max_val, input int unsigned depth_val);
      write_reg(rtq_pkg::CSR_MAX_ENTRIES, max_val[rtq_pkg::CSR_DATA_W-1:0]);
      // the bit above the depth field is random and must be ignored
      write_reg(rtq_pkg::CSR_RELEASE_DEPTH,
                {1'($urandom_range(1)), depth_val[rtq_pkg::DEPTH_W-1:0]});
   endtask

   task automatic add_push(input logic [rtq_pkg::SEQ_W-1:0] s,
                           input logic [rtq_pkg::HANDLE_W-1:0] h,
                           input logic [rtq_pkg::LEN_W-1:0] l);
      pkt_cmd_type c;
      c.kind = rtq_pkg::REQ_PUSH;
      c.ign = 1'($urandom_range(1));
      c.seq = s;
      c.handle = h;
      c.len = l;
      pkt_backlog.insert(pkt_backlog.size(), c);
   endtask

   task automatic add_pop(input logic ign);
      pkt_cmd_type c;
      c.kind = rtq_pkg::REQ_POP;
      c.ign = ign;
      c.seq = 16'($urandom);
      c.handle = 16'($urandom);
      c.len = 11'($urandom);
      pkt_backlog.insert(pkt_backlog.size(), c);
   endtask

   task automatic drain();
      while (pkt_backlog.size() != 0 || req_tvalid || owed_results.size() != 0)
         @(posedge clock);
   endtask

   // mostly an in-order stream with jitter, some far jumps and random noise
   task automatic run_phase(input int unsigned max_val, input int unsigned depth_val,
                            input int n, input int pop_pct, input bit leap);
      logic [rtq_pkg::SEQ_W-1:0] stream, s;
      int i, pick;
      configure(max_val, depth_val);
      stream = last_out + 16'd1;
      if (leap) stream = stream + 16'($urandom_range(16'h7000));
      for (i = 0; i < n; i++) begin
         if ($urandom_range(99) < pop_pct) begin
            add_pop($urandom_range(99) < 35);
         end else begin
            pick = $urandom_range(99);
            if (pick < 88) begin
               s = stream + 16'($urandom_range(11)) - 16'd3;
               stream = stream + 16'($urandom_range(1));
            end else if (pick < 94) begin
               s = stream + 16'h8000;
            end else begin
               s = 16'($urandom);
            end
            add_push(s, 16'($urandom), 11'($urandom_range(2047)));
         end
      end
      drain();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      configure(4, 2);
      add_pop(1'b0);                        // empty queue
      add_pop(1'b1);
      add_push(16'h0000, 16'h0000, 11'h000);
      add_pop(1'b0);                        // below release depth
      add_push(16'hFFFF, 16'hFFFF, 11'h7FF);  // wraps ahead of zero
      add_push(16'h0000, 16'h1234, 11'h055);  // duplicate
      add_push(16'h0002, 16'h0002, 11'h002);
      add_push(16'h0001, 16'h0001, 11'h001);  // lands in the middle
      add_push(16'h0003, 16'h0003, 11'h003);  // evicts the oldest
      add_push(16'hFFFE, 16'hAAAA, 11'h2AA);  // new entry is itself the oldest
      add_pop(1'b0);
      add_push(16'h0000, 16'h5555, 11'h555);  // late, equal to last out
      add_push(16'hFFF0, 16'h00F0, 11'h0F0);  // late, before last out
      add_push(16'h8000, 16'h8000, 11'h400);  // half-range distance
      add_push(16'h8001, 16'h8001, 11'h401);
      repeat (4) add_pop(1'b1);
      add_pop(1'b0);
      add_pop(1'b1);
      drain();

      run_phase(16, 4, 145, 40, 1'b0);
      stall_asks = stall_asks + 1;
      run_phase(64, 63, 200, 20, 1'b0);
      run_phase(8, 3, 145, 40, 1'b1);        // lowered below the held count
      run_phase(1, 0, 145, 45, 1'b0);
      idle_pct = 0;
      run_phase(127, 10, 145, 25, 1'b1);     // clamped to capacity
      idle_pct = 14;
      run_phase(0, 0, 145, 40, 1'b0);        // falls back to defaults
      run_phase(20, 40, 145, 30, 1'b1);
      run_phase(2, 1, 145, 50, 1'b0);
      repeat (3) run_phase($urandom_range(127), $urandom_range(63), 145, 35, 1'b1);

      repeat (12) @(posedge clock);
      if (mismatches == 0 && owed_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/rtq_pkg.sv
rtl/core/rtq_cell.sv
rtl/core/rtq_chain.sv
rtl/core/rtp_reorder_queue.sv
rtl/core/rtq_checker.sv
sim/tb_rtp_reorder_queue.sv
